### rtl/vice_pkg.sv
// Shared types, constants and helpers for the vector instruction cycle estimator.
// No dependencies; used by vice_recip_div and vector_insn_cycle_estimator_top.

package vice_pkg;

    localparam int VL_BITS_DEF = 16;
    localparam int FUNC_W      = 4;
    localparam int EW_W        = 7;
    localparam int USER_W      = FUNC_W + 1;
    localparam int LANE_W      = 5;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int DEN_W       = 7;
    localparam int CNT_W       = 25;
    localparam int OFF_W       = CFG_W + 2;
    localparam int Q_FRAC      = 8;
    localparam int BEAT_BITS   = 64;
    localparam int EW_DEFAULT  = 32;
    localparam int LANES_DEF   = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_UNKNOWN = 4'd0,
        FUNC_ALU     = 4'd1,
        FUNC_MUL     = 4'd2,
        FUNC_FMA     = 4'd3,
        FUNC_DIV     = 4'd4,
        FUNC_UNIT    = 4'd5,
        FUNC_STRIDED = 4'd6,
        FUNC_GATHER  = 4'd7,
        FUNC_REDINT  = 4'd8,
        FUNC_REDFP   = 4'd9,
        FUNC_OTHER   = 4'd10
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LANE_COUNT   = 4'd0,
        CFG_MEM_LATENCY  = 4'd1,
        CFG_SYNC         = 4'd2,
        CFG_STRIDE_BASE  = 4'd3,
        CFG_STRIDE_COST  = 4'd4,
        CFG_GATHER_START = 4'd5,
        CFG_GATHER_COST  = 4'd6,
        CFG_DRAIN        = 4'd7
    } cfg_idx_t;

    // control fields that ride along the pipeline with each item
    typedef struct packed {
        logic              kill;
        logic [FUNC_W-1:0] func;
        logic              ovh;
        logic [EW_W-1:0]   ew;
    } ctl_t;

    function automatic logic [2:0] ceil_log2_lanes(input logic [LANE_W-1:0] n);
        logic [2:0] r;
        if (n <= LANE_W'(1))
            r = 3'd0;
        else if (n <= LANE_W'(2))
            r = 3'd1;
        else if (n <= LANE_W'(4))
            r = 3'd2;
        else if (n <= LANE_W'(8))
            r = 3'd3;
        else if (n <= LANE_W'(16))
            r = 3'd4;
        else
            r = 3'd5;
        return r;
    endfunction

endpackage

### rtl/vice_recip_div.sv
// Three-stage unsigned divider: reciprocal multiply, back-multiply, one-step correction.
// Depends on vice_pkg for the default divisor width.

module vice_recip_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = vice_pkg::DEN_W
) (
    input  logic             clk,
    input  logic [2:0]       adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [NUM_W:0]   recip,
    output logic [NUM_W-1:0] quo
);

    logic [2*NUM_W-1:0]       est_full;
    logic [NUM_W-1:0]         num_a_reg;
    logic [NUM_W-1:0]         num_b_reg;
    logic [NUM_W-1:0]         est_a_reg;
    logic [NUM_W-1:0]         est_b_reg;
    logic [DEN_W-1:0]         den_a_reg;
    logic [DEN_W-1:0]         den_b_reg;
    logic [NUM_W+DEN_W-1:0]   prod_b_reg;
    logic [NUM_W+DEN_W-1:0]   rem;
    logic [NUM_W-1:0]         quo_reg;

    // recip = floor(2^NUM_W / den): estimate is the quotient or one short
    assign est_full = num * recip;
    assign rem      = {{DEN_W{1'b0}}, num_b_reg} - prod_b_reg;
    assign quo      = quo_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            num_a_reg <= num;
            den_a_reg <= den;
            est_a_reg <= est_full[2*NUM_W-1:NUM_W];
        end
        if (adv[1])
        begin
            num_b_reg  <= num_a_reg;
            den_b_reg  <= den_a_reg;
            est_b_reg  <= est_a_reg;
            prod_b_reg <= est_a_reg * den_a_reg;
        end
        if (adv[2])
            quo_reg <= est_b_reg + NUM_W'(rem >= (NUM_W+DEN_W)'(den_b_reg));
    end

endmodule

### rtl/vector_insn_cycle_estimator_top.sv
// Vector instruction cycle estimator: ten-stage pipeline, one instruction per cycle
// while the output is not stalled; m_tvalid is the valid bit of the last stage.
// The four reciprocal dividers (beats, per-lane divide, SIMD width, reduction
// elements) are pipelined, each three stages.
// Reset clears all stage valid bits and loads the register defaults; no clearing pass.
// Depends on vice_pkg and vice_recip_div.

module vector_insn_cycle_estimator_top #(
    parameter int VL_BITS = vice_pkg::VL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // vector_length, element_width (zero padded to bytes)
    input  logic [((VL_BITS+vice_pkg::EW_W+7)/8)*8-1:0] s_tdata,
    // func, overhead_mode
    input  logic [vice_pkg::USER_W-1:0]           s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // cycle_count (zero padded to bytes)
    output logic [((vice_pkg::CNT_W+7)/8)*8-1:0]  m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vice_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vice_pkg::CFG_W-1:0]            cfg_data
);

    localparam int EW_W    = vice_pkg::EW_W;
    localparam int CFG_W   = vice_pkg::CFG_W;
    localparam int LANE_W  = vice_pkg::LANE_W;
    localparam int CNT_W   = vice_pkg::CNT_W;
    localparam int OFF_W   = vice_pkg::OFF_W;
    localparam int DEN_W   = vice_pkg::DEN_W;
    localparam int Q_FRAC  = vice_pkg::Q_FRAC;
    localparam int BEAT_SH = $clog2(vice_pkg::BEAT_BITS);
    localparam int OUT_W   = ((CNT_W + 7) / 8) * 8;
    localparam int NSTG    = 10;
    localparam int VE_W    = VL_BITS + EW_W;
    localparam int DN      = VE_W + 1 - BEAT_SH;
    localparam int PQ_W    = VL_BITS + CFG_W;
    localparam int SR_W    = PQ_W + 1 - Q_FRAC;
    localparam int TW      = VL_BITS + 11;
    localparam int CW      = (TW > CNT_W) ? TW : CNT_W;
    localparam int NLANE   = 2 ** LANE_W;
    localparam int NEW     = 2 ** EW_W;

    // configuration registers
    logic [LANE_W-1:0] lane_count_reg;
    logic [CFG_W-1:0]  mem_lat_reg;
    logic [CFG_W-1:0]  sync_reg;
    logic [CFG_W-1:0]  stride_base_reg;
    logic [CFG_W-1:0]  stride_cost_reg;
    logic [CFG_W-1:0]  gather_start_reg;
    logic [CFG_W-1:0]  gather_cost_reg;
    logic [CFG_W-1:0]  drain_reg;

    logic [LANE_W-1:0] nl;
    logic [2:0]        lg;
    logic [DN:0]       rn;

    logic [DN:0]       rn_tab [NLANE];
    logic [EW_W-1:0]   w_tab  [NEW];
    logic [DN:0]       rw_tab [NEW];

    logic [NSTG-1:0]   v_reg;
    logic [NSTG-1:0]   v_next;
    logic [NSTG:0]     adv;
    vice_pkg::ctl_t    ctl_reg [NSTG-1];
    vice_pkg::ctl_t    ctl_in;

    logic [VL_BITS-1:0] in_vl;
    logic [EW_W-1:0]    in_ew;
    logic [EW_W-1:0]    ew_eff;

    // stage 0
    logic [VL_BITS-1:0] vl0_reg;
    logic [EW_W-1:0]    w0_reg;
    logic [DN:0]        mw0_reg;
    logic [VE_W-1:0]    pve0_reg;
    logic [PQ_W-1:0]    ps0_reg;
    logic [PQ_W-1:0]    pg0_reg;
    // stage 1
    logic [VE_W:0]      pve_rnd;
    logic [PQ_W:0]      ps_rnd;
    logic [PQ_W:0]      pg_rnd;
    logic [DN-1:0]      nb1_reg;
    logic [DN-1:0]      nd1_reg;
    logic [DN-1:0]      nw1_reg;
    logic [EW_W-1:0]    w1_reg;
    logic [DN:0]        mw1_reg;
    logic [SR_W-1:0]    sr1_reg;
    logic [SR_W-1:0]    gr1_reg;
    // stages 2 to 4
    logic [OFF_W-1:0]   toff_next;
    logic [OFF_W-1:0]   toff2_reg;
    logic [OFF_W-1:0]   toff3_reg;
    logic [OFF_W-1:0]   toff4_reg;
    logic [TW-1:0]      ts2_reg;
    logic [TW-1:0]      tg02_reg;
    logic [TW-1:0]      tg12_reg;
    logic [TW-1:0]      tmem3_reg;
    logic [TW-1:0]      tmem4_reg;
    logic [DN-1:0]      qb;
    logic [DN-1:0]      qd;
    logic [DN-1:0]      qw;
    // stages 5 to 8
    logic [DN+7:0]      divp_full;
    logic [TW-1:0]      tpre_next;
    logic [DN-1:0]      ne5_reg;
    logic [TW-1:0]      divp5_reg;
    logic [TW-1:0]      tpre5_reg;
    logic [TW-1:0]      tpre6_reg;
    logic [TW-1:0]      tpre7_reg;
    logic [TW-1:0]      tpre8_reg;
    logic [DN-1:0]      qe;
    // stage 9
    logic [TW-1:0]      t_sel;
    logic [CW-1:0]      t_ext;
    logic [CNT_W-1:0]   out_next;
    logic [CNT_W-1:0]   out_reg;

    // ---------------------------------------------------------------- tables
    for (genvar gi = 0; gi < NLANE; gi++)
    begin : g_rn
        localparam longint unsigned RN = (64'd1 << DN) / ((gi == 0) ? 1 : gi);
        assign rn_tab[gi] = (DN+1)'(RN);
    end

    // SIMD width per element width; a zero code reads as the default width
    for (genvar gi = 0; gi < NEW; gi++)
    begin : g_w
        localparam int EWE = (gi == 0) ? vice_pkg::EW_DEFAULT : gi;
        localparam int WV  = ((vice_pkg::BEAT_BITS / EWE) == 0) ? 1
                                                                : (vice_pkg::BEAT_BITS / EWE);
        localparam longint unsigned RW = (64'd1 << DN) / WV;
        assign w_tab[gi]  = EW_W'(WV);
        assign rw_tab[gi] = (DN+1)'(RW);
    end

    // ---------------------------------------------------------- configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_count_reg   <= LANE_W'(vice_pkg::LANES_DEF);
            mem_lat_reg      <= CFG_W'(10);
            sync_reg         <= CFG_W'(1);
            stride_base_reg  <= CFG_W'(4);
            stride_cost_reg  <= CFG_W'(256);
            gather_start_reg <= CFG_W'(4);
            gather_cost_reg  <= CFG_W'(256);
            drain_reg        <= CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vice_pkg::CFG_LANE_COUNT:   lane_count_reg   <= cfg_data[LANE_W-1:0];
                vice_pkg::CFG_MEM_LATENCY:  mem_lat_reg      <= cfg_data;
                vice_pkg::CFG_SYNC:         sync_reg         <= cfg_data;
                vice_pkg::CFG_STRIDE_BASE:  stride_base_reg  <= cfg_data;
                vice_pkg::CFG_STRIDE_COST:  stride_cost_reg  <= cfg_data;
                vice_pkg::CFG_GATHER_START: gather_start_reg <= cfg_data;
                vice_pkg::CFG_GATHER_COST:  gather_cost_reg  <= cfg_data;
                vice_pkg::CFG_DRAIN:        drain_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    assign nl = (lane_count_reg == '0) ? LANE_W'(vice_pkg::LANES_DEF) : lane_count_reg;
    assign lg = vice_pkg::ceil_log2_lanes(nl);
    assign rn = rn_tab[nl];

    // -------------------------------------------------------------- handshake
    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[NSTG] = m_tready;
        for (int k = NSTG - 1; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    always_comb
    begin
        v_next = v_reg;
        if (adv[0])
            v_next[0] = s_tvalid;
        for (int k = 1; k < NSTG; k++)
            if (adv[k])
                v_next[k] = v_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign s_tready = adv[0];
    assign m_tvalid = v_reg[NSTG-1];
    assign m_tdata  = OUT_W'(out_reg);

    // ---------------------------------------------------------------- stage 0
    assign in_vl  = s_tdata[VL_BITS-1:0];
    assign in_ew  = s_tdata[VL_BITS+EW_W-1:VL_BITS];
    assign ew_eff = (in_ew == '0) ? EW_W'(vice_pkg::EW_DEFAULT) : in_ew;

    always_comb
    begin
        ctl_in.kill = (s_tuser[vice_pkg::FUNC_W-1:0] == vice_pkg::FUNC_UNKNOWN)
                      || (in_vl == '0);
        ctl_in.func = s_tuser[vice_pkg::FUNC_W-1:0];
        ctl_in.ovh  = s_tuser[vice_pkg::FUNC_W];
        ctl_in.ew   = ew_eff;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ctl_reg[0] <= ctl_in;
            vl0_reg    <= in_vl;
            w0_reg     <= w_tab[in_ew];
            mw0_reg    <= rw_tab[in_ew];
            pve0_reg   <= in_vl * ew_eff;
            ps0_reg    <= in_vl * stride_cost_reg;
            pg0_reg    <= in_vl * gather_cost_reg;
        end
        for (int k = 1; k < NSTG - 1; k++)
            if (adv[k])
                ctl_reg[k] <= ctl_reg[k-1];
    end

    // ---------------------------------------------------------------- stage 1
    // ceil(a/(64*nl)) taken as ceil(ceil(a/64)/nl); products with the Q8.8 costs rounded half up
    assign pve_rnd = (VE_W+1)'(pve0_reg) + (VE_W+1)'(vice_pkg::BEAT_BITS - 1);
    assign ps_rnd  = (PQ_W+1)'(ps0_reg) + (PQ_W+1)'(1 << (Q_FRAC - 1));
    assign pg_rnd  = (PQ_W+1)'(pg0_reg) + (PQ_W+1)'(1 << (Q_FRAC - 1));

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            nb1_reg <= pve_rnd[VE_W:BEAT_SH] + DN'(nl) - DN'(1);
            nd1_reg <= DN'(vl0_reg) + DN'(nl) - DN'(1);
            nw1_reg <= DN'(vl0_reg) + DN'(w0_reg) - DN'(1);
            w1_reg  <= w0_reg;
            mw1_reg <= mw0_reg;
            sr1_reg <= ps_rnd[PQ_W:Q_FRAC];
            gr1_reg <= pg_rnd[PQ_W:Q_FRAC];
        end
    end

    // ----------------------------------------------------------- stages 2..4
    vice_recip_div #(.NUM_W(DN), .DEN_W(DEN_W)) u_div_beats (
        .clk   (clk),
        .adv   (adv[4:2]),
        .num   (nb1_reg),
        .den   (DEN_W'(nl)),
        .recip (rn),
        .quo   (qb)
    );

    vice_recip_div #(.NUM_W(DN), .DEN_W(DEN_W)) u_div_lane (
        .clk   (clk),
        .adv   (adv[4:2]),
        .num   (nd1_reg),
        .den   (DEN_W'(nl)),
        .recip (rn),
        .quo   (qd)
    );

    vice_recip_div #(.NUM_W(DN), .DEN_W(DEN_W)) u_div_simd (
        .clk   (clk),
        .adv   (adv[4:2]),
        .num   (nw1_reg),
        .den   (DEN_W'(w1_reg)),
        .recip (mw1_reg),
        .quo   (qw)
    );

    // fixed part of the count added to the beats
    always_comb
    begin
        case (ctl_reg[1].func)
            vice_pkg::FUNC_MUL,
            vice_pkg::FUNC_FMA:  toff_next = OFF_W'(2);
            vice_pkg::FUNC_UNIT: toff_next = OFF_W'(1) + OFF_W'(sync_reg)
                                             + (ctl_reg[1].ovh ? '0 : OFF_W'(mem_lat_reg));
            default:             toff_next = OFF_W'(1);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            toff2_reg <= toff_next;
            ts2_reg   <= TW'(stride_base_reg) + TW'(sr1_reg);
            tg02_reg  <= TW'(gather_start_reg) + TW'(gr1_reg);
            tg12_reg  <= TW'(sync_reg) + TW'(drain_reg);
        end
        if (adv[3])
        begin
            toff3_reg <= toff2_reg;
            tmem3_reg <= (ctl_reg[2].func == vice_pkg::FUNC_STRIDED) ? ts2_reg
                                                                      : tg02_reg + tg12_reg;
        end
        if (adv[4])
        begin
            toff4_reg <= toff3_reg;
            tmem4_reg <= tmem3_reg;
        end
    end

    // ---------------------------------------------------------------- stage 5
    assign divp_full = qd * ({1'b0, ctl_reg[4].ew} + 8'd2);

    always_comb
    begin
        case (ctl_reg[4].func)
            vice_pkg::FUNC_STRIDED,
            vice_pkg::FUNC_GATHER: tpre_next = tmem4_reg;
            default:               tpre_next = TW'(toff4_reg) + TW'(qb);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            ne5_reg   <= qw + DN'(nl) - DN'(1);
            divp5_reg <= TW'(divp_full);
            tpre5_reg <= tpre_next;
        end
        if (adv[6])
            tpre6_reg <= (ctl_reg[5].func == vice_pkg::FUNC_DIV) ? divp5_reg + TW'(2)
                                                                  : tpre5_reg;
        if (adv[7])
            tpre7_reg <= tpre6_reg;
        if (adv[8])
            tpre8_reg <= tpre7_reg;
    end

    // ----------------------------------------------------------- stages 6..8
    vice_recip_div #(.NUM_W(DN), .DEN_W(DEN_W)) u_div_elem (
        .clk   (clk),
        .adv   (adv[8:6]),
        .num   (ne5_reg),
        .den   (DEN_W'(nl)),
        .recip (rn),
        .quo   (qe)
    );

    // ---------------------------------------------------------------- stage 9
    always_comb
    begin
        if (ctl_reg[8].kill)
            t_sel = '0;
        else
        begin
            case (ctl_reg[8].func)
                vice_pkg::FUNC_REDINT: t_sel = TW'(1) + TW'(qe) + TW'({lg, 1'b0});
                vice_pkg::FUNC_REDFP:  t_sel = TW'(2) + TW'({qe, 1'b0})
                                               + TW'(lg) * TW'(3);
                default:               t_sel = tpre8_reg;
            endcase
        end
        t_ext    = CW'(t_sel);
        out_next = (t_ext > CW'(vice_pkg::CNT_MAX)) ? vice_pkg::CNT_MAX : t_ext[CNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[9])
            out_reg <= out_next;
    end

    // ------------------------------------------------------------- assertions
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted transaction did not enter stage 0");

    a_kill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[8] && adv[9] && ctl_reg[8].kill |=> m_tvalid && (m_tdata == '0))
        else $error("unknown unit or zero length gave a non-zero count");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[8] && !adv[8] |=> v_reg[8] && $stable(tpre8_reg))
        else $error("stalled stage 8 lost its item");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !v_reg[8] |=> !m_tvalid)
        else $error("output repeated a transaction");

endmodule

### test/testbench.sv
// Self-checking testbench for vector_insn_cycle_estimator_top: directed and random
// instruction descriptors across several register settings, results checked in order.
// Depends on vice_pkg and the estimator RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int VL_BITS_DEF = vice_pkg::VL_BITS_DEF;
    localparam int FUNC_W      = vice_pkg::FUNC_W;
    localparam int EW_W        = vice_pkg::EW_W;
    localparam int USER_W      = vice_pkg::USER_W;
    localparam int LANE_W      = vice_pkg::LANE_W;
    localparam int CFG_W       = vice_pkg::CFG_W;
    localparam int CFG_IDX_W   = vice_pkg::CFG_IDX_W;
    localparam int CNT_W       = vice_pkg::CNT_W;
    localparam int Q_FRAC      = vice_pkg::Q_FRAC;
    localparam int BEAT_BITS   = vice_pkg::BEAT_BITS;
    localparam int EW_DEFAULT  = vice_pkg::EW_DEFAULT;
    localparam int LANES_DEF   = vice_pkg::LANES_DEF;

    localparam logic [CNT_W-1:0] CNT_MAX = vice_pkg::CNT_MAX;

    localparam int TDATA_W       = ((VL_BITS_DEF + EW_W + 7) / 8) * 8;
    localparam int RDATA_W       = ((CNT_W + 7) / 8) * 8;
    localparam int NUM_REGS      = 8;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 125;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [FUNC_W-1:0]    FUNC_SPARE_LO = 4'd11;
    localparam logic [FUNC_W-1:0]    FUNC_SPARE_HI = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 4'd15;

    // receiver stall patterns
    localparam int RX_FREE   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_MOSTLY = 3;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [VL_BITS_DEF-1:0] vl;
        logic [EW_W-1:0]        ew;
        logic                   ovh;
    } insn_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic [USER_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [RDATA_W-1:0]   m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic [CFG_W-1:0]     shadow_regs [0:NUM_REGS-1];
    insn_t                insn_queue [$];
    logic [CNT_W-1:0]     pending_counts [$];
    insn_t                next_insn;

    int unsigned offered_items = 0;
    int unsigned taken_items   = 0;
    int unsigned error_count   = 0;
    int          burst_left    = 1;
    int          gap_left      = 0;
    bit          steady_sender = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int          hold_left     = 0;
    int          rx_mode       = RX_FREE;
    int          rx_mode_left  = 0;
    int unsigned rx_tick       = 0;
    logic        ready_next;

    vector_insn_cycle_estimator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned ceil_div(input longint unsigned a,
                                                 input longint unsigned b);
        return (a + b - 1) / b;
    endfunction

    function automatic logic [CNT_W-1:0] estimate_cycles(input logic [FUNC_W-1:0] func,
                                                        input logic [VL_BITS_DEF-1:0] vl,
                                                        input logic [EW_W-1:0] ew_in,
                                                        input logic ovh);
        longint unsigned ew, lanes, beats, simd, elems, lg, t, vlen;
        vlen  = vl;
        ew    = (ew_in == '0) ? EW_DEFAULT : ew_in;
        lanes = (shadow_regs[vice_pkg::CFG_LANE_COUNT][LANE_W-1:0] == '0) ? LANES_DEF
                : shadow_regs[vice_pkg::CFG_LANE_COUNT][LANE_W-1:0];
        beats = ceil_div(vlen * ew, BEAT_BITS * lanes);
        if (beats == 0)
            beats = 1;
        simd = BEAT_BITS / ew;
        if (simd == 0)
            simd = 1;
        elems = ceil_div(vlen, lanes * simd);
        lg = 0;
        while ((64'd1 << lg) < lanes)
            lg++;
        if (func == vice_pkg::FUNC_UNKNOWN || vlen == 0)
            t = 0;
        else
            case (func)
                vice_pkg::FUNC_MUL, vice_pkg::FUNC_FMA: t = 2 + beats;
                vice_pkg::FUNC_DIV: t = 2 + (ew + 2) * ceil_div(vlen, lanes);
                vice_pkg::FUNC_UNIT:
                begin
                    t = 1 + shadow_regs[vice_pkg::CFG_SYNC] + beats;
                    if (!ovh)
                        t += shadow_regs[vice_pkg::CFG_MEM_LATENCY];
                end
                vice_pkg::FUNC_STRIDED:
                    t = shadow_regs[vice_pkg::CFG_STRIDE_BASE]
                        + ((vlen * shadow_regs[vice_pkg::CFG_STRIDE_COST]
                            + (1 << (Q_FRAC - 1))) >> Q_FRAC);
                vice_pkg::FUNC_GATHER:
                    t = shadow_regs[vice_pkg::CFG_GATHER_START]
                        + ((vlen * shadow_regs[vice_pkg::CFG_GATHER_COST]
                            + (1 << (Q_FRAC - 1))) >> Q_FRAC)
                        + shadow_regs[vice_pkg::CFG_SYNC] + shadow_regs[vice_pkg::CFG_DRAIN];
                vice_pkg::FUNC_REDINT: t = 1 + elems + 2 * lg;
                vice_pkg::FUNC_REDFP:  t = 2 + 2 * elems + 3 * lg;
                default:               t = 1 + beats;   // alu, other and unassigned codes
            endcase
        if (t > CNT_MAX)
            t = CNT_MAX;
        return CNT_W'(t);
    endfunction

    function automatic insn_t make_insn(input logic [FUNC_W-1:0] func,
                                        input logic [VL_BITS_DEF-1:0] vl,
                                        input logic [EW_W-1:0] ew, input logic ovh);
        insn_t x;
        x.func = func;
        x.vl   = vl;
        x.ew   = ew;
        x.ovh  = ovh;
        return x;
    endfunction

    function automatic insn_t random_insn();
        insn_t x;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        x.func = (sel == 0) ? FUNC_W'($urandom_range(0, 15)) : FUNC_W'($urandom_range(1, 10));
        sel = $urandom_range(0, 9);
        case (sel)
            0:       x.vl = '0;
            1:       x.vl = '1;
            2, 3:    x.vl = VL_BITS_DEF'($urandom_range(1, 16));
            4:       x.vl = VL_BITS_DEF'((1 << $urandom_range(0, 15)) + $urandom_range(0, 2) - 1);
            default: x.vl = VL_BITS_DEF'($urandom);
        endcase
        sel = $urandom_range(0, 9);
        case (sel)
            0:       x.ew = '0;
            1:       x.ew = EW_W'(8);
            2:       x.ew = EW_W'(16);
            3:       x.ew = EW_W'(BEAT_BITS);
            4:       x.ew = EW_W'($urandom_range(65, 127));
            default: x.ew = EW_W'($urandom_range(0, 127));
        endcase
        x.ovh = 1'($urandom_range(0, 1));
        return x;
    endfunction

    function automatic logic [CFG_W-1:0] random_reg_value();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        // indexes past the register list are dropped by the block
        if (idx < NUM_REGS)
            shadow_regs[idx] = (idx == vice_pkg::CFG_LANE_COUNT) ? CFG_W'(val[LANE_W-1:0])
                                                                 : val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (insn_queue.size() != 0 || offered_items != taken_items
               || pending_counts.size() != 0)
            @(negedge clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && taken_items == offered_items)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (insn_queue.size() != 0)
            begin
                next_insn = insn_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= TDATA_W'({next_insn.ew, next_insn.vl});
                s_tuser  <= {next_insn.ovh, next_insn.func};
                offered_items++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = (steady_sender || $urandom_range(0, 1)) ? 0
                                 : $urandom_range(1, 8);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stall pattern, redrawn when its run ends; long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holds_served != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (rx_mode_left <= 0)
            begin
                rx_mode      = $urandom_range(RX_FREE, RX_MOSTLY);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            rx_tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
                case (rx_mode)
                    RX_FREE:   ready_next = 1'b1;
                    RX_COIN:   ready_next = 1'($urandom_range(0, 1));
                    RX_SPARSE: ready_next = (rx_tick % 4 == 0);
                    default:   ready_next = ($urandom_range(0, 7) != 0);
                endcase
            m_tready <= ready_next;
        end
    end

    // monitor: predict on input transactions, compare on output transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pending_counts.push_back(estimate_cycles(s_tuser[FUNC_W-1:0],
                                                         s_tdata[VL_BITS_DEF-1:0],
                                                         s_tdata[VL_BITS_DEF+EW_W-1:VL_BITS_DEF],
                                                         s_tuser[FUNC_W]));
                taken_items++;
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_counts.size() == 0)
                    flag_mismatch($sformatf("unexpected result cycle_count=%0d",
                                            m_tdata[CNT_W-1:0]));
                else if (m_tdata[CNT_W-1:0] !== pending_counts[0])
                    flag_mismatch($sformatf("cycle_count got %0d want %0d",
                                            m_tdata[CNT_W-1:0], pending_counts[0]));
                if (pending_counts.size() != 0)
                    void'(pending_counts.pop_front());
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        insn_t          directed [$];
        int             p, i, n;
        logic [CFG_W-1:0] v;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        shadow_regs[vice_pkg::CFG_LANE_COUNT]   = CFG_W'(4);
        shadow_regs[vice_pkg::CFG_MEM_LATENCY]  = CFG_W'(10);
        shadow_regs[vice_pkg::CFG_SYNC]         = CFG_W'(1);
        shadow_regs[vice_pkg::CFG_STRIDE_BASE]  = CFG_W'(4);
        shadow_regs[vice_pkg::CFG_STRIDE_COST]  = CFG_W'(256);
        shadow_regs[vice_pkg::CFG_GATHER_START] = CFG_W'(4);
        shadow_regs[vice_pkg::CFG_GATHER_COST]  = CFG_W'(256);
        shadow_regs[vice_pkg::CFG_DRAIN]        = CFG_W'(1);

        directed.push_back(make_insn(vice_pkg::FUNC_UNKNOWN, 16'd100, 7'd32, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_ALU, 16'd0, 7'd32, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_ALU, 16'd1, 7'd0, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_MUL, 16'd256, 7'd64, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_FMA, 16'hFFFF, 7'd64, 1'b1));
        directed.push_back(make_insn(vice_pkg::FUNC_DIV, 16'd17, 7'd8, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_DIV, 16'hFFFF, 7'd127, 1'b1));
        directed.push_back(make_insn(vice_pkg::FUNC_UNIT, 16'd1000, 7'd16, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_UNIT, 16'd1000, 7'd16, 1'b1));
        directed.push_back(make_insn(vice_pkg::FUNC_STRIDED, 16'd3, 7'd32, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_STRIDED, 16'hFFFF, 7'd1, 1'b1));
        directed.push_back(make_insn(vice_pkg::FUNC_GATHER, 16'd7, 7'd0, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_GATHER, 16'hFFFF, 7'd64, 1'b1));
        directed.push_back(make_insn(vice_pkg::FUNC_REDINT, 16'd33, 7'd8, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_REDINT, 16'hFFFF, 7'd127, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_REDFP, 16'd9, 7'd0, 1'b1));
        directed.push_back(make_insn(vice_pkg::FUNC_REDFP, 16'hFFFF, 7'd1, 1'b0));
        directed.push_back(make_insn(vice_pkg::FUNC_OTHER, 16'd500, 7'd65, 1'b0));
        directed.push_back(make_insn(FUNC_SPARE_LO, 16'd77, 7'd16, 1'b0));
        directed.push_back(make_insn(FUNC_SPARE_HI, 16'hFFFF, 7'd127, 1'b1));
        directed.push_back(make_insn(vice_pkg::FUNC_UNKNOWN, 16'd0, 7'd0, 1'b1));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase 0 runs on reset values, 1 all-ones, 2 all-zero, 4 carries the hold-off
        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                for (i = 0; i < NUM_REGS; i++)
                begin
                    case (p)
                        1:       v = '1;
                        2:       v = (i == vice_pkg::CFG_LANE_COUNT) ? CFG_W'(32) : '0;
                        default: v = random_reg_value();
                    endcase
                    if (i == vice_pkg::CFG_LANE_COUNT && p == 3)
                        v = CFG_W'(1);
                    if (i == vice_pkg::CFG_LANE_COUNT && p == 4)
                        v = CFG_W'(16);
                    write_reg(CFG_IDX_W'(i), v);
                end
                if (p == 3)
                begin
                    write_reg(CFG_SPARE_LO, CFG_W'($urandom));
                    write_reg(CFG_SPARE_HI, '1);
                end
            end
            if (p < 2)
                foreach (directed[i])
                    insn_queue.push_back(directed[i]);
            steady_sender = (p == 4);
            for (n = 0; n < PHASE_ITEMS; n++)
                insn_queue.push_back(random_insn());
            if (p == 4)
                hold_requests++;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_counts.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
